// ----- design/rab_pkg.sv -----
// Shared types and constants for the ray/box slab test.
package rab_pkg;

    localparam int DATA_W        = 32;
    localparam int DEF_FRAC_BITS = 16;
    localparam int DEF_ZERO_TOL  = 1;
    localparam int CFG_IDX_W     = 3;

    localparam logic signed [DATA_W-1:0] BOX_MIN_RST = -32'sd65536;
    localparam logic signed [DATA_W-1:0] BOX_MAX_RST = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } t_reg_idx;

    // per-axis flags that ride alongside the divider pipeline
    typedef struct packed {
        logic flat;
        logic fmiss;
        logic neg_lo;
        logic neg_hi;
    } t_axis_sb;

endpackage

// ----- design/rab_div.sv -----
// Pipelined unsigned restoring divider, one quotient bit per register stage.
module rab_div import rab_pkg::*; #(
    parameter int NW = 48,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [NW-1:0] o_quo
);

    logic [DW-1:0] r_rem [NW];
    logic [NW-1:0] r_num [NW];
    logic [NW-1:0] r_quo [NW];
    logic [DW-1:0] r_den [NW];

    for (genvar s = 0; s < NW; s++) begin : g_stage
        logic [DW-1:0] rem_i;
        logic [NW-1:0] num_i;
        logic [NW-1:0] quo_i;
        logic [DW-1:0] den_i;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] n_rem;

        if (s == 0) begin : g_first
            assign rem_i = '0;
            assign num_i = i_num;
            assign quo_i = '0;
            assign den_i = i_den;
        end else begin : g_next
            assign rem_i = r_rem[s-1];
            assign num_i = r_num[s-1];
            assign quo_i = r_quo[s-1];
            assign den_i = r_den[s-1];
        end

        assign trial = {rem_i, num_i[NW-1]};
        assign diff  = trial - {1'b0, den_i};
        assign ge    = trial >= {1'b0, den_i};
        assign n_rem = ge ? diff[DW-1:0] : trial[DW-1:0];

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_num[s] <= {num_i[NW-2:0], 1'b0};
            r_quo[s] <= {quo_i[NW-2:0], ge};
            r_den[s] <= den_i;
        end
    end

    assign o_quo = r_quo[NW-1];

endmodule

// ----- design/rab_axis.sv -----
// One axis lane: slab distances, two dividers, sign restore and ordering.
module rab_axis import rab_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int ZERO_TOL  = DEF_ZERO_TOL,
    parameter int NW        = DATA_W + FRAC_BITS,
    parameter int TW        = NW + 2
) (
    input  logic                     i_clk,
    input  logic signed [DATA_W-1:0] i_org,
    input  logic signed [DATA_W-1:0] i_dir,
    input  logic signed [DATA_W-1:0] i_lo,
    input  logic signed [DATA_W-1:0] i_hi,
    output logic signed [TW-1:0]     o_lo,
    output logic signed [TW-1:0]     o_hi,
    output logic                     o_flat,
    output logic                     o_fmiss
);

    localparam logic signed [TW-1:0] SENT_POS = {2'b01, {NW{1'b0}}};
    localparam logic signed [TW-1:0] SENT_NEG = -SENT_POS;

    // front end
    logic signed [DATA_W:0] d_lo, d_hi, dir_x;
    logic        [DATA_W:0] a_lo, a_hi, a_dir;
    logic                   n_flat;

    assign d_lo  = {i_lo[DATA_W-1], i_lo} - {i_org[DATA_W-1], i_org};
    assign d_hi  = {i_hi[DATA_W-1], i_hi} - {i_org[DATA_W-1], i_org};
    assign dir_x = {i_dir[DATA_W-1], i_dir};
    assign a_lo  = d_lo[DATA_W] ? -d_lo : d_lo;
    assign a_hi  = d_hi[DATA_W] ? -d_hi : d_hi;
    assign a_dir = dir_x[DATA_W] ? -dir_x : dir_x;
    assign n_flat = a_dir <= (DATA_W+1)'(ZERO_TOL);

    logic [NW-1:0]     r_num_lo, r_num_hi;
    logic [DATA_W-1:0] r_den;
    t_axis_sb          r_sb0;

    always_ff @(posedge i_clk) begin
        r_num_lo     <= {a_lo[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        r_num_hi     <= {a_hi[DATA_W-1:0], {FRAC_BITS{1'b0}}};
        r_den        <= a_dir[DATA_W-1:0];
        r_sb0.flat   <= n_flat;
        r_sb0.fmiss  <= n_flat && ((i_org > i_hi) || (i_org < i_lo));
        r_sb0.neg_lo <= d_lo[DATA_W] ^ i_dir[DATA_W-1];
        r_sb0.neg_hi <= d_hi[DATA_W] ^ i_dir[DATA_W-1];
    end

    logic [NW-1:0] q_lo, q_hi;

    rab_div #(.NW(NW), .DW(DATA_W)) u_div_lo (
        .i_clk (i_clk),
        .i_num (r_num_lo),
        .i_den (r_den),
        .o_quo (q_lo)
    );

    rab_div #(.NW(NW), .DW(DATA_W)) u_div_hi (
        .i_clk (i_clk),
        .i_num (r_num_hi),
        .i_den (r_den),
        .o_quo (q_hi)
    );

    // flags delayed to match the divider depth
    t_axis_sb r_sb [NW];

    always_ff @(posedge i_clk) begin
        r_sb[0] <= r_sb0;
        for (int k = 1; k < NW; k++) begin
            r_sb[k] <= r_sb[k-1];
        end
    end

    logic signed [TW-1:0] t1, t2, n_lo, n_hi;

    always_comb begin
        t1 = r_sb[NW-1].neg_lo ? -$signed({2'b00, q_lo}) : $signed({2'b00, q_lo});
        t2 = r_sb[NW-1].neg_hi ? -$signed({2'b00, q_hi}) : $signed({2'b00, q_hi});
        if (r_sb[NW-1].flat) begin
            n_lo = SENT_NEG;
            n_hi = SENT_POS;
        end else if (t1 < t2) begin
            n_lo = t1;
            n_hi = t2;
        end else begin
            n_lo = t2;
            n_hi = t1;
        end
    end

    logic signed [TW-1:0] r_lo, r_hi;
    logic                 r_flat, r_fmiss;

    always_ff @(posedge i_clk) begin
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_flat  <= r_sb[NW-1].flat;
        r_fmiss <= r_sb[NW-1].fmiss;
    end

    assign o_lo    = r_lo;
    assign o_hi    = r_hi;
    assign o_flat  = r_flat;
    assign o_fmiss = r_fmiss;

endmodule

// ----- design/ray_aabb_slab_test_core.sv -----
// Top level of the pipelined ray versus axis-aligned box slab test.
//
// Usage:
//  - Input: drive the ray on i_origin_* / i_dir_* (signed fixed point,
//    FRAC_BITS fraction bits) and pulse i_start. A beat is taken at each
//    clock edge with i_start high and o_busy low; o_busy is always low,
//    so one ray can enter every cycle.
//  - Box: six bound registers written through i_cfg_we / i_cfg_addr /
//    i_cfg_data (index 0..2 min x,y,z; 3..5 max x,y,z). Other indexes
//    are dropped. Write only while no ray is in flight.
//  - Output: o_done is high for exactly one cycle per ray with o_hit and
//    o_t_entry (saturated to 32 bits, zero on a miss). Results come out
//    in input order.
//  - Path: lane input registers, the bit-per-stage dividers (32 +
//    FRAC_BITS stages deep), lane output registers, the reduce
//    register and the output register.
//  - Throughput: one ray per cycle.
//  - Reset (synchronous, i_rst_n low) empties the pipeline and loads the
//    box with raw +/-65536 on every axis ([-1.0, +1.0] at FRAC_BITS = 16).
//  - The receiver has no way to stall; every result is shown once.
module ray_aabb_slab_test_core import rab_pkg::*; #(
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int ZERO_TOL  = DEF_ZERO_TOL
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [DATA_W-1:0]        i_cfg_data,
    input  logic signed [DATA_W-1:0] i_origin_x,
    input  logic signed [DATA_W-1:0] i_origin_y,
    input  logic signed [DATA_W-1:0] i_origin_z,
    input  logic signed [DATA_W-1:0] i_dir_x,
    input  logic signed [DATA_W-1:0] i_dir_y,
    input  logic signed [DATA_W-1:0] i_dir_z,
    output logic                     o_done,
    output logic                     o_hit,
    output logic signed [DATA_W-1:0] o_t_entry
);

    localparam int NW  = DATA_W + FRAC_BITS;  // quotient / numerator width
    localparam int TW  = NW + 2;              // signed t width incl. sentinels
    localparam int LAT = NW + 4;

    localparam logic signed [TW-1:0] T_MAX = TW'(32'sh7FFF_FFFF);
    localparam logic signed [TW-1:0] T_MIN = TW'(-33'sh8000_0000);

    // box registers
    logic signed [DATA_W-1:0] r_box_lo [3];
    logic signed [DATA_W-1:0] r_box_hi [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_box_lo[a] <= BOX_MIN_RST;
                r_box_hi[a] <= BOX_MAX_RST;
            end
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_MIN_X: r_box_lo[0] <= i_cfg_data;
                REG_MIN_Y: r_box_lo[1] <= i_cfg_data;
                REG_MIN_Z: r_box_lo[2] <= i_cfg_data;
                REG_MAX_X: r_box_hi[0] <= i_cfg_data;
                REG_MAX_Y: r_box_hi[1] <= i_cfg_data;
                REG_MAX_Z: r_box_hi[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // three axis lanes
    logic signed [DATA_W-1:0] org [3];
    logic signed [DATA_W-1:0] dir [3];
    logic signed [TW-1:0]     ax_lo [3];
    logic signed [TW-1:0]     ax_hi [3];
    logic [2:0]               ax_flat, ax_fmiss;

    assign org[0] = i_origin_x;
    assign org[1] = i_origin_y;
    assign org[2] = i_origin_z;
    assign dir[0] = i_dir_x;
    assign dir[1] = i_dir_y;
    assign dir[2] = i_dir_z;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        rab_axis #(
            .FRAC_BITS (FRAC_BITS),
            .ZERO_TOL  (ZERO_TOL),
            .NW        (NW),
            .TW        (TW)
        ) u_axis (
            .i_clk   (i_clk),
            .i_org   (org[a]),
            .i_dir   (dir[a]),
            .i_lo    (r_box_lo[a]),
            .i_hi    (r_box_hi[a]),
            .o_lo    (ax_lo[a]),
            .o_hi    (ax_hi[a]),
            .o_flat  (ax_flat[a]),
            .o_fmiss (ax_fmiss[a])
        );
    end

    // valid bits, aligned with the lane outputs at the top entry
    logic [NW+1:0] r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NW:0], accept};
        end
    end

    // reduce: latest entry, earliest exit (flat axes carry neutral sentinels)
    logic signed [TW-1:0] n_near, n_far;

    always_comb begin
        n_near = ax_lo[0];
        n_far  = ax_hi[0];
        for (int a = 1; a < 3; a++) begin
            if (ax_lo[a] > n_near) n_near = ax_lo[a];
            if (ax_hi[a] < n_far)  n_far  = ax_hi[a];
        end
    end

    logic signed [TW-1:0] r_near, r_far;
    logic                 r_miss0, r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_vld[NW+1];
        end
        r_near  <= n_near;
        r_far   <= n_far;
        r_miss0 <= (&ax_flat) || (|ax_fmiss);
    end

    // final decision and saturation
    logic                     miss;
    logic signed [DATA_W-1:0] t_sat;

    assign miss = r_miss0 || (r_near > r_far) || (r_far < 0);

    always_comb begin
        if (r_near > T_MAX)      t_sat = 32'sh7FFF_FFFF;
        else if (r_near < T_MIN) t_sat = 32'sh8000_0000;
        else                     t_sat = r_near[DATA_W-1:0];
    end

    logic                     r_done, r_hit;
    logic signed [DATA_W-1:0] r_t_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_v3;
        end
        r_hit     <= !miss;
        r_t_entry <= miss ? '0 : t_sat;
    end

    assign o_done    = r_done;
    assign o_hit     = r_hit;
    assign o_t_entry = r_t_entry;

    // checks
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_busy)
        else $error("busy raised in a fully pipelined core");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_done)
        else $error("result beat missing at expected latency");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_t_entry == '0))
        else $error("miss beat carries nonzero entry");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_v3))
        else $error("result beat without a ray behind it");

endmodule
